// ===== design/mouse_cursor_tracker_core_assert.svh =====
// assertion macros for the mouse cursor tracker
// expects aclk and aresetn in the scope of the including module
`ifndef MOUSE_CURSOR_TRACKER_CORE_ASSERT_SVH
`define MOUSE_CURSOR_TRACKER_CORE_ASSERT_SVH

// check on every edge outside reset
`define MCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check on every edge, reset included
`define MCT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/mct_pkg.sv =====
// shared types and constants for the mouse cursor tracker
// no dependencies
package mct_pkg;

    localparam int unsigned CoordW  = 10;
    localparam int unsigned RowsW   = 10;
    localparam int unsigned FrameW  = 11;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned TicksW  = 8;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgW    = 10;

    // item kinds
    localparam logic KIND_MOUSE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_X_MAX        = 2'd0,
        CFG_Y_MAX        = 2'd1,
        CFG_SCROLL_ROWS  = 2'd2,
        CFG_RESYNC_TICKS = 2'd3
    } cfg_idx_t;

    // register reset values
    localparam logic [CoordW-1:0] X_MAX_RST        = 10'd639;
    localparam logic [CoordW-1:0] Y_MAX_RST        = 10'd479;
    localparam logic [RowsW-1:0]  SCROLL_ROWS_RST  = 10'd480;
    localparam logic [TicksW-1:0] RESYNC_TICKS_RST = 8'd20;

    typedef struct packed {
        logic             kind;
        logic [ByteW-1:0] mouse_byte;
    } in_t;

    typedef struct packed {
        logic [RowsW-1:0]  row_offset;
        logic [CoordW-1:0] cursor_x;
        logic [CoordW-1:0] cursor_y;
        logic [ByteW-1:0]  button_byte;
    } out_t;

endpackage

// ===== design/mouse_cursor_tracker_core.sv =====
// mouse cursor tracker: ps/2 packet decode, clamped cursor, ping-pong frame scroll
// depends on mct_pkg and mouse_cursor_tracker_core_assert.svh
//
//  channel   dir   handshake          payload
//  s_        in    s_valid/s_ready    in_t  (kind, mouse_byte)
//  m_        out   m_valid/m_ready    out_t (row_offset, cursor_x, cursor_y, button_byte)
//  cfg_      in    cfg_wr_en          cfg_index, cfg_wdata
//
// one transaction per cycle sustained while the result register is empty or being taken; a tick's result
// passes through the input register, then the state update and the result register
// mouse bytes update state only and give no result
// a tick waits in the input register only while the result register is full and not taken
// aresetn is synchronous, active low; clears control state and config to defaults
`include "mouse_cursor_tracker_core_assert.svh"

module mouse_cursor_tracker_core
    import mct_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  in_t                s_data,

    output logic               m_valid,
    input  logic               m_ready,
    output out_t               m_data,

    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_wdata
);

    // configuration registers
    logic [CoordW-1:0] x_max_reg;
    logic [CoordW-1:0] y_max_reg;
    logic [RowsW-1:0]  scroll_rows_reg;
    logic [TicksW-1:0] resync_ticks_reg;

    // input stage
    logic in_valid_reg, in_valid_next;
    in_t  in_reg;

    // tracker state
    logic [FrameW-1:0] frame_count_reg, frame_count_next;
    logic [CoordW-1:0] pos_x_reg, pos_x_next;
    logic [CoordW-1:0] pos_y_reg, pos_y_next;
    logic [ByteW-1:0]  buttons_reg, buttons_next;
    logic [1:0]        bytes_held_reg, bytes_held_next;
    logic [ByteW-1:0]  held_first_reg, held_first_next;
    logic [ByteW-1:0]  held_second_reg, held_second_next;
    logic [TicksW-1:0] stall_ticks_reg, stall_ticks_next;

    // result stage
    logic out_valid_reg, out_valid_next;
    out_t out_reg, out_next;

    logic advance;
    logic is_tick;

    // packet math
    logic signed [11:0] sum_x;
    logic signed [11:0] sum_y;
    logic [CoordW-1:0]  clamp_x;
    logic [CoordW-1:0]  clamp_y;

    // frame counter math
    logic [RowsW-1:0]  rows_eff;
    logic [FrameW-1:0] period;
    logic [FrameW-1:0] fc_inc;
    logic [FrameW-1:0] fc_new;
    logic [FrameW-1:0] offset_w;
    logic [TicksW-1:0] stall_inc;

    assign is_tick = (in_reg.kind == KIND_TICK);
    // a tick moves on only when the result register can take it
    assign advance = in_valid_reg && (!is_tick || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // cursor update from a completed packet: first byte held, second held, third live
    always_comb begin
        sum_x = $signed({2'b00, pos_x_reg})
              + $signed({{4{held_first_reg[4]}}, held_second_reg});
        sum_y = $signed({2'b00, pos_y_reg})
              - $signed({{4{held_first_reg[5]}}, in_reg.mouse_byte});

        if (sum_x[11]) begin
            clamp_x = '0;
        end else if (sum_x[10:0] > {1'b0, x_max_reg}) begin
            clamp_x = x_max_reg;
        end else begin
            clamp_x = sum_x[9:0];
        end

        if (sum_y[11]) begin
            clamp_y = '0;
        end else if (sum_y[10:0] > {1'b0, y_max_reg}) begin
            clamp_y = y_max_reg;
        end else begin
            clamp_y = sum_y[9:0];
        end
    end

    // ping-pong frame counter: counts up to 2*rows-2, offset folds back past rows
    always_comb begin
        rows_eff = (scroll_rows_reg == '0) ? 10'd1 : scroll_rows_reg;
        period   = {rows_eff, 1'b0} - 11'd1;
        fc_inc   = frame_count_reg + 11'd1;
        fc_new   = (fc_inc >= period) ? '0 : fc_inc;
        offset_w = (fc_new >= {1'b0, rows_eff}) ? (period - fc_new) : fc_new;
        stall_inc = stall_ticks_reg + 8'd1;
    end

    always_comb begin
        in_valid_next    = in_valid_reg;
        frame_count_next = frame_count_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        buttons_next     = buttons_reg;
        bytes_held_next  = bytes_held_reg;
        held_first_next  = held_first_reg;
        held_second_next = held_second_reg;
        stall_ticks_next = stall_ticks_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (s_ready) begin
            in_valid_next = s_valid;
        end

        if (advance) begin
            if (!is_tick) begin
                case (bytes_held_reg)
                    2'd0: begin
                        held_first_next = in_reg.mouse_byte;
                        bytes_held_next = 2'd1;
                    end
                    2'd1: begin
                        held_second_next = in_reg.mouse_byte;
                        bytes_held_next  = 2'd2;
                    end
                    default: begin
                        // third byte completes the packet
                        buttons_next     = held_first_reg;
                        pos_x_next       = clamp_x;
                        pos_y_next       = clamp_y;
                        stall_ticks_next = '0;
                        bytes_held_next  = 2'd0;
                    end
                endcase
            end else begin
                frame_count_next       = fc_new;
                out_valid_next         = 1'b1;
                out_next.row_offset    = offset_w[RowsW-1:0];
                out_next.cursor_x      = pos_x_reg;
                out_next.cursor_y      = pos_y_reg;
                out_next.button_byte   = buttons_reg;
                // partial packet timeout, flush clears the count too
                if (bytes_held_reg != 2'd0) begin
                    if (stall_inc >= resync_ticks_reg) begin
                        bytes_held_next  = 2'd0;
                        stall_ticks_next = '0;
                    end else begin
                        stall_ticks_next = stall_inc;
                    end
                end
            end
        end
    end

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            frame_count_reg  <= '0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            buttons_reg      <= '0;
            bytes_held_reg   <= '0;
            stall_ticks_reg  <= '0;
            x_max_reg        <= X_MAX_RST;
            y_max_reg        <= Y_MAX_RST;
            scroll_rows_reg  <= SCROLL_ROWS_RST;
            resync_ticks_reg <= RESYNC_TICKS_RST;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            frame_count_reg <= frame_count_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            buttons_reg     <= buttons_next;
            bytes_held_reg  <= bytes_held_next;
            stall_ticks_reg <= stall_ticks_next;
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_X_MAX:        x_max_reg        <= cfg_wdata[CoordW-1:0];
                    CFG_Y_MAX:        y_max_reg        <= cfg_wdata[CoordW-1:0];
                    CFG_SCROLL_ROWS:  scroll_rows_reg  <= cfg_wdata[RowsW-1:0];
                    CFG_RESYNC_TICKS: resync_ticks_reg <= cfg_wdata[TicksW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_reg <= s_data;
        end
        held_first_reg  <= held_first_next;
        held_second_reg <= held_second_next;
        out_reg         <= out_next;
    end

    // a new result only ever comes from a tick leaving the input stage
    `MCT_ASSERT(a_result_from_tick, $rose(out_valid_reg) |-> $past(advance && is_tick), "no tick")
    // the byte count never reaches three
    `MCT_ASSERT(a_bytes_held_range, bytes_held_reg != 2'd3, "bytes_held out of range")
    // frame counter stays below the largest period
    `MCT_ASSERT(a_frame_range, frame_count_reg <= 11'd2044, "frame counter past period")
    // timeout count runs only with a partial packet pending
    `MCT_ASSERT(a_stall_needs_bytes, stall_ticks_reg != '0 |-> bytes_held_reg != 2'd0, "stray count")
    // reset empties both stages
    `MCT_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !in_valid_reg && !out_valid_reg, "not empty")

endmodule
